### hdl/asd_pkg.sv
// Shared constants and register codes for the accelerometer step detector.
`timescale 1ns / 1ps
`default_nettype none

package asd_pkg;

   // Default widths of the sample axes and the millisecond timestamp.
   localparam int ASD_SAMPLE_BITS = 13;
   localparam int ASD_TIME_BITS   = 48;

   // Fixed field widths.
   localparam int COUNT_W = 24;
   localparam int GAP_W   = 16;

   // Running average: new = (15 * old + mag) >> 4.
   localparam int AVG_SHIFT = 4;
   // Threshold margin: thr = avg + (avg >> 4).
   localparam int THR_SHIFT = 4;

   // Reset values.
   localparam int AVG_RESET = 1000000;
   localparam int GAP_RESET = 250;
   // The average must at least hold its reset value.
   localparam int AVG_MIN_W = $clog2(AVG_RESET + 1);

   // Saturation value of the step count.
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // Configuration port.
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = GAP_W;
   localparam logic [CSR_INDEX_W-1:0] REG_ENABLE  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MIN_GAP = 1'd1;

endpackage : asd_pkg

`default_nettype wire

### hdl/asd_req_if.sv
// Sample channel: valid/ready handshake with three axes and a timestamp.
`timescale 1ns / 1ps
`default_nettype none

interface asd_req_if #(
   parameter int SAMPLE_BITS = asd_pkg::ASD_SAMPLE_BITS,
   parameter int TIME_BITS   = asd_pkg::ASD_TIME_BITS
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] axis_x;
   logic signed [SAMPLE_BITS-1:0] axis_y;
   logic signed [SAMPLE_BITS-1:0] axis_z;
   logic [TIME_BITS-1:0]          sample_time_ms;

   modport source (output valid, axis_x, axis_y, axis_z, sample_time_ms, input ready);
   modport sink (input valid, axis_x, axis_y, axis_z, sample_time_ms, output ready);
endinterface : asd_req_if

`default_nettype wire

### hdl/asd_rsp_if.sv
// Result channel: valid/ready handshake with the step flag and step count.
`timescale 1ns / 1ps
`default_nettype none

interface asd_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        step_seen;
   logic [asd_pkg::COUNT_W-1:0] step_total;

   modport source (output valid, step_seen, step_total, input ready);
   modport sink (input valid, step_seen, step_total, output ready);
endinterface : asd_rsp_if

`default_nettype wire

### hdl/accel_step_detector.sv
// Top level of the accelerometer threshold-crossing step detector.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake     Payload
// req_chan  in         valid/ready   axis_x, axis_y, axis_z, sample_time_ms
// rsp_chan  out        valid/ready   step_seen, step_total
// csr_*     in         write enable  csr_index, csr_wdata
//
// One sample per clock is accepted unless a stalled result has filled the
// pipeline; each sample passes the input register, squares, magnitude sum,
// then the result register loaded by the state update.
// The step state recurrence (average, threshold, crossing, gap) closes
// within the last stage. Reset is synchronous and needs no clearing
// pass. A stalled result only blocks stages that are full: bubbles ahead
// of it are filled, so up to four transactions are held during a stall.

module accel_step_detector #(
   parameter int SAMPLE_BITS = asd_pkg::ASD_SAMPLE_BITS,
   parameter int TIME_BITS   = asd_pkg::ASD_TIME_BITS
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   asd_req_if.sink                                 req_chan,
   asd_rsp_if.source                               rsp_chan,
   input  wire logic                               csr_we,
   input  wire logic [asd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [asd_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import asd_pkg::*;

   // Squared magnitude: three squares of 2^(S-1) at most stay below 2^(2S).
   localparam int MAG_W = 2 * SAMPLE_BITS;
   localparam int AVG_W = (MAG_W > AVG_MIN_W) ? MAG_W : AVG_MIN_W;
   localparam int ACC_W = AVG_W + AVG_SHIFT;
   localparam int THR_W = AVG_W + 1;

   // Pipeline valid bits and load enables.
   logic s0_valid_ff, s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic s0_load, s1_load, s2_load, s3_load;

   // Stage 0: registered sample.
   logic [SAMPLE_BITS-1:0] s0_x_ff, s0_y_ff, s0_z_ff;
   logic [TIME_BITS-1:0]   s0_time_ff;

   // Stage 1: registered squares.
   logic [SAMPLE_BITS-1:0] abs_x, abs_y, abs_z;
   logic [MAG_W-1:0]       s1_sq_x_ff, s1_sq_y_ff, s1_sq_z_ff;
   logic [MAG_W-1:0]       s1_sq_x_in, s1_sq_y_in, s1_sq_z_in;
   logic [TIME_BITS-1:0]   s1_time_ff;

   // Stage 2: registered magnitude.
   logic [MAG_W-1:0]       s2_mag_ff, s2_mag_in;
   logic [TIME_BITS-1:0]   s2_time_ff;

   // Stage 3: result registers.
   logic                   step_seen_ff, step_seen_in;
   logic [COUNT_W-1:0]     step_total_ff;

   // Configuration registers.
   logic                   enable_ff;
   logic [GAP_W-1:0]       min_gap_ff;

   // Detector state.
   logic [AVG_W-1:0]       avg_ff, avg_in;
   logic [MAG_W-1:0]       prev_mag_ff;
   logic [TIME_BITS-1:0]   last_step_ff;
   logic [COUNT_W-1:0]     count_ff, count_in;

   // State update terms.
   logic [ACC_W-1:0]       avg_acc;
   logic [THR_W-1:0]       thr;
   logic [THR_W-1:0]       mag_ext, prev_ext;
   logic [TIME_BITS-1:0]   gap;
   logic                   crossing, gap_ok;
   logic                   state_update;
   logic                   count_clear;

   // A stage loads when it is empty or its content moves on.
   assign s3_load = !s3_valid_ff || rsp_chan.ready;
   assign s2_load = !s2_valid_ff || s3_load;
   assign s1_load = !s1_valid_ff || s2_load;
   assign s0_load = !s0_valid_ff || s1_load;
   assign req_chan.ready = s0_load;

   // Valid bits of the pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s0_load) begin
            s0_valid_ff <= req_chan.valid;
         end
         if (s1_load) begin
            s1_valid_ff <= s0_valid_ff;
         end
         if (s2_load) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_load) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (s0_load) begin
         s0_x_ff    <= req_chan.axis_x;
         s0_y_ff    <= req_chan.axis_y;
         s0_z_ff    <= req_chan.axis_z;
         s0_time_ff <= req_chan.sample_time_ms;
      end
   end

   // Absolute values and squares; the most negative code maps to 2^(S-1).
   always_comb begin
      abs_x = s0_x_ff[SAMPLE_BITS-1] ? SAMPLE_BITS'(~s0_x_ff + 1'b1) : s0_x_ff;
      abs_y = s0_y_ff[SAMPLE_BITS-1] ? SAMPLE_BITS'(~s0_y_ff + 1'b1) : s0_y_ff;
      abs_z = s0_z_ff[SAMPLE_BITS-1] ? SAMPLE_BITS'(~s0_z_ff + 1'b1) : s0_z_ff;
      s1_sq_x_in = MAG_W'(abs_x) * MAG_W'(abs_x);
      s1_sq_y_in = MAG_W'(abs_y) * MAG_W'(abs_y);
      s1_sq_z_in = MAG_W'(abs_z) * MAG_W'(abs_z);
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_sq_x_ff <= s1_sq_x_in;
         s1_sq_y_ff <= s1_sq_y_in;
         s1_sq_z_ff <= s1_sq_z_in;
         s1_time_ff <= s0_time_ff;
      end
   end

   // Sum of the squares.
   assign s2_mag_in = s1_sq_x_ff + s1_sq_y_ff + s1_sq_z_ff;

   always_ff @(posedge clock) begin
      if (s2_load) begin
         s2_mag_ff  <= s2_mag_in;
         s2_time_ff <= s1_time_ff;
      end
   end

   // Average, threshold, crossing test and gap test for the sample in stage 2.
   always_comb begin
      avg_acc  = {avg_ff, {AVG_SHIFT{1'b0}}} - ACC_W'(avg_ff) + ACC_W'(s2_mag_ff);
      avg_in   = avg_acc[ACC_W-1:AVG_SHIFT];
      thr      = THR_W'(avg_in) + THR_W'(avg_in >> THR_SHIFT);
      mag_ext  = THR_W'(s2_mag_ff);
      prev_ext = THR_W'(prev_mag_ff);
      crossing = (mag_ext > thr) && (prev_ext <= thr);
      gap      = s2_time_ff - last_step_ff;
      gap_ok   = gap > TIME_BITS'(min_gap_ff);

      state_update = s2_valid_ff && s3_load && enable_ff;
      step_seen_in = enable_ff && crossing && gap_ok;
      count_in     = (step_seen_in && (count_ff != COUNT_MAX)) ? count_ff + 1'b1 : count_ff;
   end

   assign count_clear = csr_we && (csr_index == REG_ENABLE) && csr_wdata[0];

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= 1'b0;
         min_gap_ff <= GAP_W'(GAP_RESET);
      end else if (csr_we) begin
         unique case (csr_index)
            REG_ENABLE: begin
               enable_ff <= csr_wdata[0];
            end
            REG_MIN_GAP: begin
               min_gap_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // Detector state; only enabled transactions update it, and a write of 1 to the enable register clears the count.
   always_ff @(posedge clock) begin
      if (reset) begin
         avg_ff       <= AVG_W'(AVG_RESET);
         prev_mag_ff  <= '0;
         last_step_ff <= '0;
         count_ff     <= '0;
      end else begin
         if (state_update) begin
            avg_ff      <= avg_in;
            prev_mag_ff <= s2_mag_ff;
            if (step_seen_in) begin
               last_step_ff <= s2_time_ff;
            end
         end
         priority if (count_clear) begin
            count_ff <= '0;
         end else if (state_update) begin
            count_ff <= count_in;
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (s3_load && s2_valid_ff) begin
         step_seen_ff  <= step_seen_in;
         step_total_ff <= count_in;
      end
   end

   assign rsp_chan.valid      = s3_valid_ff;
   assign rsp_chan.step_seen  = step_seen_ff;
   assign rsp_chan.step_total = step_total_ff;

endmodule : accel_step_detector

`default_nettype wire
